// ===== sv/jdcd_pkg.sv =====
// Constants and month table for the Julian day to calendar date unit.
package jdcd_pkg;

    localparam int JD_W    = 39;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 30;
    localparam int DOY_W   = 9;
    localparam int MONTHS  = 12;

    // Pipeline depth from input register to result register inclusive
    localparam int LATENCY = 10;

    localparam logic [JD_W-1:0] JD_MAX      = 39'd365244221425;
    localparam logic [JD_W-1:0] GREG_START  = 39'd2299161;
    localparam logic [JD_W-1:0] GREG_OFFSET = 39'd1721426;

    localparam logic [17:0] CYC400_DAYS = 18'd146097;
    localparam logic [15:0] CYC100_DAYS = 16'd36524;
    localparam logic [10:0] CYC4_DAYS   = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [8:0]  LEAP_DAYS   = 9'd366;

    // floor(2^42 / 146097), applied to d >> 8 with a 34 bit shift; low by at most one
    localparam logic [24:0] CYC400_RECIP = 25'd30103605;
    localparam int          CYC400_SHIFT = 34;
    // ceil(2^33 / 1461), exact for values below 2^22
    localparam logic [22:0] JUL_RECIP    = 23'd5879490;
    localparam int          JUL_SHIFT    = 33;
    // ceil(2^27 / 1461), exact for values below 36525
    localparam logic [16:0] CYC4_RECIP   = 17'd91868;
    localparam int          CYC4_SHIFT   = 27;

    // Julian day 0 falls in astronomical year -4712
    localparam logic [12:0] BC_PIVOT = 13'd4712;
    localparam logic [12:0] BC_FIRST = 13'd4713;

    localparam logic [29:0] YEARS_400 = 30'd400;
    localparam logic [29:0] YEARS_100 = 30'd100;

    // First day of year of month m (0 = January)
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] s;
        unique case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && m >= 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ===== sv/julian_day_to_calendar_date_unit.sv =====
// Julian day number to calendar date converter, ten stage pipeline.
// The result strobe o_valid is the start transfer carried through the valid shift register r_vld.
// Throughput: one transfer per cycle; busy is held low and never stalls start.
// The 146097-day division is a reciprocal multiply plus one correction step,
// spread over stages 3 to 5; the rest are compares and constant multiplies.
// Reset (synchronous, active low) clears the valid pipeline only.
module julian_day_to_calendar_date_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [jdcd_pkg::JD_W-1:0]      i_julian_day,
    output logic                           o_valid,
    output logic [jdcd_pkg::DAY_W-1:0]     o_day_of_month,
    output logic [jdcd_pkg::MONTH_W-1:0]   o_month_number,
    output logic [jdcd_pkg::YEAR_W-1:0]    o_year_number,
    output logic                           o_before_christ
);

    localparam int LAT = jdcd_pkg::LATENCY;

    logic [LAT-1:0] r_vld;

    // stage 1
    logic [38:0] r_s1_jd;
    // stage 2
    logic [38:0] r_s2_d;
    logic [21:0] r_s2_rj;
    logic        r_s2_greg;
    logic [38:0] n_sat;
    // stage 3
    logic [21:0] r_s3_q0;
    logic [18:0] r_s3_dlo;
    logic [10:0] r_s3_rj;
    logic [10:0] r_s3_cj;
    logic        r_s3_greg;
    logic [55:0] n_gp;
    logic [44:0] n_jp;
    // stage 4
    logic [18:0] r_s4_rem0;
    logic [21:0] r_s4_q0;
    logic [10:0] r_s4_remj;
    logic [10:0] r_s4_cj;
    logic        r_s4_greg;
    logic [18:0] n_pq;
    logic [10:0] n_jprod;
    // stage 5
    logic [17:0] r_s5_d1;
    logic [21:0] r_s5_n400;
    logic [8:0]  r_s5_jdoy;
    logic [12:0] r_s5_jyear;
    logic        r_s5_jbc;
    logic        r_s5_jleap;
    logic        r_s5_greg;
    logic [17:0] n_d1;
    logic [21:0] n_n400;
    logic [1:0]  n_yi;
    logic [8:0]  n_jdoy;
    logic [12:0] n_t;
    logic        n_jbc;
    logic [12:0] n_jyear;
    // stage 6
    logic [15:0] r_s6_d2;
    logic [1:0]  r_s6_n100;
    logic [21:0] r_s6_n400;
    logic [8:0]  r_s6_jdoy;
    logic [12:0] r_s6_jyear;
    logic        r_s6_jbc;
    logic        r_s6_jleap;
    logic        r_s6_greg;
    logic [1:0]  n_n100;
    logic [15:0] n_d2;
    // stage 7
    logic [15:0] r_s7_d2;
    logic [4:0]  r_s7_n4;
    logic [1:0]  r_s7_n100;
    logic [21:0] r_s7_n400;
    logic [8:0]  r_s7_jdoy;
    logic [12:0] r_s7_jyear;
    logic        r_s7_jbc;
    logic        r_s7_jleap;
    logic        r_s7_greg;
    logic [32:0] n_n4p;
    // stage 8
    logic [10:0] r_s8_d3;
    logic [29:0] r_s8_yhi;
    logic [4:0]  r_s8_n4;
    logic [1:0]  r_s8_n100;
    logic [8:0]  r_s8_jdoy;
    logic [12:0] r_s8_jyear;
    logic        r_s8_jbc;
    logic        r_s8_jleap;
    logic        r_s8_greg;
    logic [10:0] n_d3;
    logic [29:0] n_yhi;
    // stage 9
    logic [8:0]  r_s9_doy;
    logic        r_s9_leap;
    logic [29:0] r_s9_year;
    logic        r_s9_bc;
    logic [1:0]  n_n1;
    logic [8:0]  n_gdoy;
    logic [29:0] n_gyear;
    logic        n_gleap;
    // result
    logic [4:0]  r_out_day;
    logic [3:0]  r_out_month;
    logic [29:0] r_out_year;
    logic        r_out_bc;
    logic [3:0]  n_month_idx;
    logic [4:0]  n_day;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // stage 1: capture
    always_ff @(posedge i_clk) begin
        r_s1_jd <= i_julian_day;
    end

    // stage 2: saturate, pick calendar, rebase to 1 January 1 AD (Gregorian)
    always_comb begin
        n_sat = (r_s1_jd > jdcd_pkg::JD_MAX) ? jdcd_pkg::JD_MAX : r_s1_jd;
    end

    always_ff @(posedge i_clk) begin
        r_s2_greg <= (n_sat >= jdcd_pkg::GREG_START);
        r_s2_d    <= n_sat - jdcd_pkg::GREG_OFFSET;
        r_s2_rj   <= n_sat[21:0];
    end

    // stage 3: reciprocal multiplies for the 400 year and Julian 4 year cycles
    assign n_gp = 56'(r_s2_d[38:8]) * 56'(jdcd_pkg::CYC400_RECIP);
    assign n_jp = 45'(r_s2_rj) * 45'(jdcd_pkg::JUL_RECIP);

    always_ff @(posedge i_clk) begin
        r_s3_q0   <= n_gp[jdcd_pkg::CYC400_SHIFT +: 22];
        r_s3_dlo  <= r_s2_d[18:0];
        r_s3_rj   <= r_s2_rj[10:0];
        r_s3_cj   <= n_jp[jdcd_pkg::JUL_SHIFT +: 11];
        r_s3_greg <= r_s2_greg;
    end

    // stage 4: remainders; both fit in their low bits, so only those are formed
    assign n_pq    = r_s3_q0[18:0] * 19'(jdcd_pkg::CYC400_DAYS);
    assign n_jprod = r_s3_cj * jdcd_pkg::CYC4_DAYS;

    always_ff @(posedge i_clk) begin
        r_s4_rem0 <= r_s3_dlo - n_pq;
        r_s4_q0   <= r_s3_q0;
        r_s4_remj <= r_s3_rj - n_jprod;
        r_s4_cj   <= r_s3_cj;
        r_s4_greg <= r_s3_greg;
    end

    // stage 5: correct the 400 year quotient; finish the Julian date
    always_comb begin
        if (r_s4_rem0 >= 19'(jdcd_pkg::CYC400_DAYS)) begin
            n_d1   = 18'(r_s4_rem0 - 19'(jdcd_pkg::CYC400_DAYS));
            n_n400 = r_s4_q0 + 22'd1;
        end else begin
            n_d1   = r_s4_rem0[17:0];
            n_n400 = r_s4_q0;
        end
        // Julian cycle starts with its leap year
        priority if (r_s4_remj >= 11'd1096) begin
            n_yi   = 2'd3;
            n_jdoy = 9'(r_s4_remj - 11'd1096);
        end else if (r_s4_remj >= 11'd731) begin
            n_yi   = 2'd2;
            n_jdoy = 9'(r_s4_remj - 11'd731);
        end else if (r_s4_remj >= 11'(jdcd_pkg::LEAP_DAYS)) begin
            n_yi   = 2'd1;
            n_jdoy = 9'(r_s4_remj - 11'(jdcd_pkg::LEAP_DAYS));
        end else begin
            n_yi   = 2'd0;
            n_jdoy = r_s4_remj[8:0];
        end
        n_t   = {r_s4_cj[10:0], 2'b00} + 13'(n_yi);
        // astronomical year zero and below are BC
        n_jbc = (n_t <= jdcd_pkg::BC_PIVOT);
        n_jyear = n_jbc ? (jdcd_pkg::BC_FIRST - n_t) : (n_t - jdcd_pkg::BC_PIVOT);
    end

    always_ff @(posedge i_clk) begin
        r_s5_d1    <= n_d1;
        r_s5_n400  <= n_n400;
        r_s5_jdoy  <= n_jdoy;
        r_s5_jyear <= n_jyear;
        r_s5_jbc   <= n_jbc;
        r_s5_jleap <= (n_yi == 2'd0);
        r_s5_greg  <= r_s4_greg;
    end

    // stage 6: centuries, last one of the cycle takes the extra day
    always_comb begin
        priority if (r_s5_d1 >= 18'd109572) begin
            n_n100 = 2'd3;
            n_d2   = 16'(r_s5_d1 - 18'd109572);
        end else if (r_s5_d1 >= 18'd73048) begin
            n_n100 = 2'd2;
            n_d2   = 16'(r_s5_d1 - 18'd73048);
        end else if (r_s5_d1 >= 18'(jdcd_pkg::CYC100_DAYS)) begin
            n_n100 = 2'd1;
            n_d2   = 16'(r_s5_d1 - 18'(jdcd_pkg::CYC100_DAYS));
        end else begin
            n_n100 = 2'd0;
            n_d2   = r_s5_d1[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_d2    <= n_d2;
        r_s6_n100  <= n_n100;
        r_s6_n400  <= r_s5_n400;
        r_s6_jdoy  <= r_s5_jdoy;
        r_s6_jyear <= r_s5_jyear;
        r_s6_jbc   <= r_s5_jbc;
        r_s6_jleap <= r_s5_jleap;
        r_s6_greg  <= r_s5_greg;
    end

    // stage 7: four year cycles
    assign n_n4p = 33'(r_s6_d2) * 33'(jdcd_pkg::CYC4_RECIP);

    always_ff @(posedge i_clk) begin
        r_s7_d2    <= r_s6_d2;
        r_s7_n4    <= n_n4p[jdcd_pkg::CYC4_SHIFT +: 5];
        r_s7_n100  <= r_s6_n100;
        r_s7_n400  <= r_s6_n400;
        r_s7_jdoy  <= r_s6_jdoy;
        r_s7_jyear <= r_s6_jyear;
        r_s7_jbc   <= r_s6_jbc;
        r_s7_jleap <= r_s6_jleap;
        r_s7_greg  <= r_s6_greg;
    end

    // stage 8: day within the four year cycle, year base
    assign n_d3  = r_s7_d2[10:0] - (11'(r_s7_n4) * jdcd_pkg::CYC4_DAYS);
    assign n_yhi = (30'(r_s7_n400) * jdcd_pkg::YEARS_400)
                 + (30'(r_s7_n100) * jdcd_pkg::YEARS_100);

    always_ff @(posedge i_clk) begin
        r_s8_d3    <= n_d3;
        r_s8_yhi   <= n_yhi;
        r_s8_n4    <= r_s7_n4;
        r_s8_n100  <= r_s7_n100;
        r_s8_jdoy  <= r_s7_jdoy;
        r_s8_jyear <= r_s7_jyear;
        r_s8_jbc   <= r_s7_jbc;
        r_s8_jleap <= r_s7_jleap;
        r_s8_greg  <= r_s7_greg;
    end

    // stage 9: single years, leap rule, calendar select
    always_comb begin
        priority if (r_s8_d3 >= 11'd1095) begin
            n_n1 = 2'd3;
        end else if (r_s8_d3 >= 11'd730) begin
            n_n1 = 2'd2;
        end else if (r_s8_d3 >= 11'(jdcd_pkg::YEAR_DAYS)) begin
            n_n1 = 2'd1;
        end else begin
            n_n1 = 2'd0;
        end
        n_gdoy  = 9'(r_s8_d3 - (11'(n_n1) * 11'(jdcd_pkg::YEAR_DAYS)));
        n_gyear = r_s8_yhi + 30'({r_s8_n4, 2'b00}) + 30'(n_n1) + 30'd1;
        // year%4 == 0 only for the last year of a cycle; a century year is the
        // last cycle of a century, leap only in the fourth century
        n_gleap = (n_n1 == 2'd3) && ((r_s8_n4 != 5'd24) || (r_s8_n100 == 2'd3));
    end

    always_ff @(posedge i_clk) begin
        if (r_s8_greg) begin
            r_s9_doy  <= n_gdoy;
            r_s9_leap <= n_gleap;
            r_s9_year <= n_gyear;
            r_s9_bc   <= 1'b0;
        end else begin
            r_s9_doy  <= r_s8_jdoy;
            r_s9_leap <= r_s8_jleap;
            r_s9_year <= 30'(r_s8_jyear);
            r_s9_bc   <= r_s8_jbc;
        end
    end

    // result stage: month and day
    always_comb begin
        n_month_idx = '0;
        for (int m = 1; m < jdcd_pkg::MONTHS; m++) begin
            if (r_s9_doy >= jdcd_pkg::month_start(4'(m), r_s9_leap)) begin
                n_month_idx = 4'(m);
            end
        end
        n_day = 5'(r_s9_doy - jdcd_pkg::month_start(n_month_idx, r_s9_leap)) + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        r_out_day   <= n_day;
        r_out_month <= n_month_idx + 4'd1;
        r_out_year  <= r_s9_year;
        r_out_bc    <= r_s9_bc;
    end

    assign o_valid         = r_vld[LAT-1];
    assign o_day_of_month  = r_out_day;
    assign o_month_number  = r_out_month;
    assign o_year_number   = r_out_year;
    assign o_before_christ = r_out_bc;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##10 o_valid)
        else $error("transfer without result strobe");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 10))
        else $error("result strobe without transfer");

    a_cyc_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && r_s5_greg) |-> (r_s5_d1 < 18'(jdcd_pkg::CYC400_DAYS)))
        else $error("400 year remainder out of range");

    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1 && o_month_number <= 4'd12
                     && o_day_of_month >= 5'd1 && o_year_number != 30'd0))
        else $error("date field out of range");

    a_bc_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_before_christ) |-> (o_year_number <= 30'd4713))
        else $error("BC year beyond first year");

endmodule

// ===== sim/julian_day_to_calendar_date_unit_test.sv =====
// Self-checking testbench for the Julian day to calendar date unit.
`timescale 1ns / 100ps

module julian_day_to_calendar_date_unit_test;

    localparam longint unsigned LAST_JD       = 64'd365244221425;
    localparam longint unsigned AD_FIRST_JD   = 64'd1721424;
    localparam longint unsigned GREG_FIRST_JD = 64'd2299161;
    localparam longint unsigned GREG_EPOCH_JD = 64'd1721426;
    localparam longint unsigned JD_SPAN       = 64'd1 << jdcd_pkg::JD_W;
    localparam int              RANDOM_ITEMS  = 1800;
    localparam int              CYCLE_LIMIT   = 300000;
    localparam int              MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef logic [jdcd_pkg::JD_W-1:0] t_jd;

    typedef struct packed {
        logic [jdcd_pkg::DAY_W-1:0]   day;
        logic [jdcd_pkg::MONTH_W-1:0] month;
        logic [jdcd_pkg::YEAR_W-1:0]  year;
        logic                         bc;
    } t_cal_date;

    typedef struct {
        t_jd jd;
        bit  wait_for_drain;
    } t_day_request;

    typedef struct {
        t_jd       jd;
        t_cal_date date;
    } t_dated_day;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic [jdcd_pkg::JD_W-1:0]      i_julian_day = '0;
    logic                           busy;
    logic                           o_valid;
    logic [jdcd_pkg::DAY_W-1:0]     o_day_of_month;
    logic [jdcd_pkg::MONTH_W-1:0]   o_month_number;
    logic [jdcd_pkg::YEAR_W-1:0]    o_year_number;
    logic                           o_before_christ;

    t_day_request pending_days[$];
    t_dated_day   expected_dates[$];
    t_dated_day   oldest;
    t_dated_day   fresh;
    logic         taken = 1'b0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           error_count = 0;
    int           checked_count = 0;
    int           bc_count = 0;
    int           julian_count = 0;
    int           greg_count = 0;
    int           sat_count = 0;
    int           cycle_count = 0;

    julian_day_to_calendar_date_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_julian_day    (i_julian_day),
        .o_valid         (o_valid),
        .o_day_of_month  (o_day_of_month),
        .o_month_number  (o_month_number),
        .o_year_number   (o_year_number),
        .o_before_christ (o_before_christ)
    );

    function automatic t_cal_date calendar_date_of(input t_jd jd);
        longint unsigned r, d, cyc, rem, yi, n400, n100, n4, n1, yr, doy, mlen;
        longint unsigned mon, mday;
        bit leap, found;
        t_cal_date date;
        r = 64'(jd);
        if (r > LAST_JD) begin
            r = LAST_JD;
        end
        date.bc = 1'b0;
        if (r < AD_FIRST_JD) begin
            // BC blocks of 1461 days open with the leap year
            cyc = r / 1461;
            rem = r % 1461;
            if (rem < 366) begin
                yi  = 0;
                doy = rem;
            end else begin
                yi  = 1 + (rem - 366) / 365;
                doy = (rem - 366) % 365;
            end
            yr      = 4713 - (4 * cyc + yi);
            leap    = (yi == 0);
            date.bc = 1'b1;
        end else if (r < GREG_FIRST_JD) begin
            d   = r - AD_FIRST_JD;
            cyc = d / 1461;
            rem = d % 1461;
            yi  = rem / 365;
            if (yi > 3) begin
                yi = 3;
            end
            doy  = rem - yi * 365;
            yr   = 4 * cyc + yi + 1;
            leap = (yr % 4 == 0);
        end else begin
            d    = r - GREG_EPOCH_JD;
            n400 = d / 146097;
            rem  = d % 146097;
            n100 = rem / 36524;
            if (n100 > 3) begin
                n100 = 3;
            end
            rem = rem - n100 * 36524;
            n4  = rem / 1461;
            rem = rem % 1461;
            n1  = rem / 365;
            if (n1 > 3) begin
                n1 = 3;
            end
            doy  = rem - n1 * 365;
            yr   = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
            leap = (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
        end
        date.year = yr[jdcd_pkg::YEAR_W-1:0];
        mon       = 64'd1;
        mday      = 64'd1;
        found     = 1'b0;
        for (int m = 0; m < 12; m++) begin
            mlen = 64'(MONTH_DAYS[m]) + ((m == 1 && leap) ? 64'd1 : 64'd0);
            if (!found && (doy < mlen || m == 11)) begin
                mon   = 64'(m) + 64'd1;
                mday  = doy + 64'd1;
                found = 1'b1;
            end else if (!found) begin
                doy = doy - mlen;
            end
        end
        date.month = mon[jdcd_pkg::MONTH_W-1:0];
        date.day   = mday[jdcd_pkg::DAY_W-1:0];
        return date;
    endfunction

    function automatic t_jd random_day_below(input longint unsigned span);
        longint unsigned raw;
        raw = {$urandom, $urandom};
        return t_jd'(raw % span);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d dates still awaited",
                     cycle_count, expected_dates.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // hold the item until the transfer happens
        end else if (pending_days.size() != 0 && burst_left != 0 &&
                     !(pending_days[0].wait_for_drain && expected_dates.size() != 0)) begin
            i_julian_day <= pending_days[0].jd;
            start        <= 1'b1;
            burst_left   <= burst_left - 1;
            void'(pending_days.pop_front());
        end else begin
            start <= 1'b0;
            if (burst_left == 0) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                              : $urandom_range(0, 3);
                end
            end
        end
    end

    // Result checker and transfer tracking
    always @(posedge i_clk) begin
        taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_dates.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= 10) begin
                        $display("Unexpected result %0d/%0d/%0d bc=%0b", o_day_of_month,
                                 o_month_number, o_year_number, o_before_christ);
                    end
                end else begin
                    oldest        = expected_dates.pop_front();
                    checked_count = checked_count + 1;
                    if (o_day_of_month !== oldest.date.day ||
                        o_month_number !== oldest.date.month ||
                        o_year_number !== oldest.date.year ||
                        o_before_christ !== oldest.date.bc) begin
                        error_count = error_count + 1;
                        if (error_count <= 10) begin
                            $display("JD %0d: expected %0d/%0d/%0d bc=%0b, got %0d/%0d/%0d bc=%0b",
                                     oldest.jd, oldest.date.day, oldest.date.month,
                                     oldest.date.year, oldest.date.bc, o_day_of_month,
                                     o_month_number, o_year_number, o_before_christ);
                        end
                    end
                end
            end
            if (start && !busy) begin
                fresh.jd       = i_julian_day;
                fresh.date     = calendar_date_of(i_julian_day);
                expected_dates = {expected_dates, fresh};
                if (i_julian_day > LAST_JD) begin
                    sat_count = sat_count + 1;
                end else if (i_julian_day < AD_FIRST_JD) begin
                    bc_count = bc_count + 1;
                end else if (i_julian_day < GREG_FIRST_JD) begin
                    julian_count = julian_count + 1;
                end else begin
                    greg_count = greg_count + 1;
                end
            end
        end
    end

    initial begin
        longint unsigned directed [$];
        longint unsigned jd;
        longint unsigned k;
        t_day_request    req;
        directed = '{
            0, 59, 60, 365, 366,                // first BC year is leap
            1721423, 1721424,                   // 31 Dec 1 BC, 1 Jan 1 AD
            1722578, 1722884,                   // 29 Feb and 31 Dec of 4 AD
            2299160, 2299161,                   // calendar switch in October 1582
            2342031, 2342032, 2415079, 2415080, // Feb/Mar of 1700 and 1900
            2451604, 2451910, 2453371,          // 2000 leap, year ends at cycle tails
            LAST_JD - 1, LAST_JD, LAST_JD + 1,
            64'd1 << (jdcd_pkg::JD_W - 1), JD_SPAN - 1
        };
        foreach (directed[i]) begin
            req.jd             = t_jd'(directed[i]);
            req.wait_for_drain = 1'b0;
            pending_days       = {pending_days, req};
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0: jd = random_day_below(AD_FIRST_JD);
                1: jd = AD_FIRST_JD + random_day_below(GREG_FIRST_JD - AD_FIRST_JD);
                2: jd = GREG_FIRST_JD - 800 + $urandom_range(0, 1600);
                3: jd = GREG_FIRST_JD + random_day_below(64'd10000000);
                4: begin
                    // straddle a 400 or 100 year boundary
                    k  = random_day_below(64'd2500000);
                    jd = GREG_EPOCH_JD + k * 146097 + $urandom_range(0, 3) * 36524
                         - 3 + $urandom_range(0, 6);
                end
                5: jd = LAST_JD - 2000 + $urandom_range(0, 4000);
                6: jd = LAST_JD + 1 + random_day_below(JD_SPAN - LAST_JD - 1);
                default: jd = random_day_below(JD_SPAN);
            endcase
            req.jd             = t_jd'(jd);
            req.wait_for_drain = (n == 0) || ($urandom_range(0, 199) == 0);
            pending_days       = {pending_days, req};
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_days.size() != 0 || start) begin
            @(negedge i_clk);
        end
        while (expected_dates.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (jdcd_pkg::LATENCY + 4) @(negedge i_clk);

        if (expected_dates.size() != 0) begin
            error_count = error_count + expected_dates.size();
        end
        $display("Checked %0d dates: %0d BC, %0d Julian AD, %0d Gregorian, %0d saturated",
                 checked_count, bc_count, julian_count, greg_count, sat_count);
        $display("Errors: %0d", error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/jdcd_pkg.sv
sv/julian_day_to_calendar_date_unit.sv
sim/julian_day_to_calendar_date_unit_test.sv
